// ===== src/rbpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpf_pkg: shared types and constants of the recursive band-pass filter
// Register map, micro-op encoding and the sequencer program of both sections.
// ----------------------------------------------------------------------------
package rbpf_pkg;

  localparam int COEF_BITS  = 32;
  localparam int PADDR_BITS = 5;
  localparam int PDATA_BITS = 32;
  localparam int PROG_LEN   = 26;
  localparam int PC_BITS    = 5;

  localparam logic [PC_BITS-1:0] LP_START = 5'd0;
  localparam logic [PC_BITS-1:0] HP_START = 5'd11;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_LP_POLE = 3'd1,
    REG_LP_PAIR = 3'd2,
    REG_LP_GAIN = 3'd3,
    REG_HP_POLE = 3'd4,
    REG_HP_PAIR = 3'd5,
    REG_HP_GAIN = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    C_LP_POLE = 3'd0,
    C_LP_PAIR = 3'd1,
    C_LP_GAIN = 3'd2,
    C_HP_POLE = 3'd3,
    C_HP_PAIR = 3'd4,
    C_HP_GAIN = 3'd5
  } coef_t;

  typedef enum logic [3:0] {
    SRC_ZERO = 4'd0,
    SRC_PROD = 4'd1,
    SRC_ACC  = 4'd2,
    SRC_N    = 4'd3,
    SRC_Y    = 4'd4,
    SRC_LPA  = 4'd5,
    SRC_LPB  = 4'd6,
    SRC_LPC  = 4'd7,
    SRC_HPA  = 4'd8,
    SRC_HPB  = 4'd9,
    SRC_HPC  = 4'd10
  } src_t;

  typedef enum logic [2:0] {
    DST_ACC = 3'd0,
    DST_N   = 3'd1,
    DST_Y   = 3'd2,
    DST_LPA = 3'd3,
    DST_LPB = 3'd4,
    DST_LPC = 3'd5,
    DST_HPA = 3'd6,
    DST_HPC = 3'd7
  } dst_t;

  // HPB is written from HPC only; it gets its own flag to keep dst_t at 3 bits
  typedef struct packed {
    logic  is_mul;
    logic  sub;
    coef_t coef;
    src_t  src_a;
    src_t  src_b;
    dst_t  dst;
    logic  wr_hpb;
    logic  last;
  } uop_t;

  function automatic uop_t op_mul(coef_t c, src_t a);
    uop_t u;
    u        = '0;
    u.is_mul = 1'b1;
    u.coef   = c;
    u.src_a  = a;
    u.src_b  = SRC_ZERO;
    u.dst    = DST_ACC;
    return u;
  endfunction

  function automatic uop_t op_alu(dst_t d, src_t a, logic sub, src_t b, logic last);
    uop_t u;
    u       = '0;
    u.sub   = sub;
    u.coef  = C_LP_POLE;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.last  = last;
    return u;
  endfunction

  function automatic uop_t op_hpb();
    uop_t u;
    u        = op_alu(DST_ACC, SRC_HPC, 1'b0, SRC_ZERO, 1'b0);
    u.wr_hpb = 1'b1;
    return u;
  endfunction

  // Program: low-pass section at LP_START, high-pass section at HP_START.
  function automatic uop_t prog_uop(logic [PC_BITS-1:0] pc);
    uop_t u;
    u = op_alu(DST_Y, SRC_Y, 1'b0, SRC_ZERO, 1'b1);
    case (pc)
      // low-pass: y = g*c ; c' = (a - p*b) + q*c ; b' = c ; a' = p*a + x
      5'd0:  u = op_mul(C_LP_GAIN, SRC_LPC);
      5'd1:  u = op_alu(DST_ACC, SRC_PROD, 1'b0, SRC_ZERO, 1'b0);
      5'd2:  u = op_mul(C_LP_POLE, SRC_LPB);
      5'd3:  u = op_alu(DST_N, SRC_LPA, 1'b1, SRC_PROD, 1'b0);
      5'd4:  u = op_mul(C_LP_PAIR, SRC_LPC);
      5'd5:  u = op_alu(DST_N, SRC_N, 1'b0, SRC_PROD, 1'b0);
      5'd6:  u = op_alu(DST_LPB, SRC_LPC, 1'b0, SRC_ZERO, 1'b0);
      5'd7:  u = op_alu(DST_LPC, SRC_N, 1'b0, SRC_ZERO, 1'b0);
      5'd8:  u = op_mul(C_LP_POLE, SRC_LPA);
      5'd9:  u = op_alu(DST_LPA, SRC_PROD, 1'b0, SRC_Y, 1'b0);
      5'd10: u = op_alu(DST_Y, SRC_ACC, 1'b0, SRC_ZERO, 1'b1);
      // high-pass: n = ((q*c - a) - p*b) + t
      5'd11: u = op_mul(C_HP_PAIR, SRC_HPC);
      5'd12: u = op_alu(DST_N, SRC_PROD, 1'b1, SRC_HPA, 1'b0);
      5'd13: u = op_mul(C_HP_POLE, SRC_HPB);
      5'd14: u = op_alu(DST_N, SRC_N, 1'b1, SRC_PROD, 1'b0);
      5'd15: u = op_alu(DST_N, SRC_N, 1'b0, SRC_Y, 1'b0);
      // a' = p*(a - t) + t
      5'd16: u = op_alu(DST_ACC, SRC_HPA, 1'b1, SRC_Y, 1'b0);
      5'd17: u = op_mul(C_HP_POLE, SRC_ACC);
      5'd18: u = op_alu(DST_HPA, SRC_PROD, 1'b0, SRC_Y, 1'b0);
      // y = g*(((n + b) - c) - c)
      5'd19: u = op_alu(DST_ACC, SRC_N, 1'b0, SRC_HPB, 1'b0);
      5'd20: u = op_alu(DST_ACC, SRC_ACC, 1'b1, SRC_HPC, 1'b0);
      5'd21: u = op_alu(DST_ACC, SRC_ACC, 1'b1, SRC_HPC, 1'b0);
      5'd22: u = op_hpb();
      5'd23: u = op_alu(DST_HPC, SRC_N, 1'b0, SRC_ZERO, 1'b0);
      5'd24: u = op_mul(C_HP_GAIN, SRC_ACC);
      5'd25: u = op_alu(DST_Y, SRC_PROD, 1'b0, SRC_ZERO, 1'b1);
      default: u = op_alu(DST_Y, SRC_Y, 1'b0, SRC_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// ===== src/rbpf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpf_if: sample channels of the recursive band-pass filter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rbpf_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          trace_start;

  modport source (output valid, output sample_in, output trace_start, input ready);
  modport sink   (input valid, input sample_in, input trace_start, output ready);
endinterface

interface rbpf_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/recursive_bandpass_iir_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_bandpass_iir_filter: third-order low-pass / high-pass IIR cascade
// Saturating fixed-point filter sequenced over one shared multiplier and
// one shared saturating adder, with an APB-style coefficient port.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents                          Transfer
//  in_chan   sink       sample_in, trace_start            valid & ready
//  out_chan  source     sample_out                        valid & ready
//  APB       slave      filter_mode, 6 Q4.28 coefficients psel&penable&pwrite
//
//  Each multiply passes through the single 25x32 multiplier in S_EXEC (low half
//  of the state word), S_MUL_HI (high half plus accumulate) and S_MUL_RND (round
//  and saturate); each add or subtract retires in S_EXEC. LP runs 4 multiplies
//  and 7 adds, HP 4 and 11. Reset (rst_n low, synchronous) clears configuration
//  registers, filter state and control.
//  in_chan is ready only when the sequencer is idle; a finished sample waits
//  in the output register, so the next sample can enter while it stalls.
//
module recursive_bandpass_iir_filter
  import rbpf_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28,
  parameter int STATE_BITS     = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rbpf_in_if.sink               in_chan,
  rbpf_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  // Multiplier split: state word = hi * 2^LO_BITS + lo (lo unsigned)
  localparam int S        = STATE_BITS;
  localparam int LO_BITS  = S / 2;
  localparam int HI_BITS  = S - LO_BITS;
  localparam int MOP_BITS = LO_BITS + 1;
  localparam int MP_BITS  = MOP_BITS + COEF_BITS;
  localparam int PW       = S + COEF_BITS;

  localparam logic signed [S-1:0] ST_MAX   = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] ST_MIN   = {1'b1, {(S-1){1'b0}}};
  localparam logic [PW:0]         RND_HALF = (PW+1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_MUL_HI  = 5'b00100,
    S_MUL_RND = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PC_BITS-1:0]   pc_r, pc_nxt;
  uop_t                 uop;

  // configuration
  logic [1:0]                  mode_r;
  logic signed [COEF_BITS-1:0] lp_pole_r, lp_pair_r, lp_gain_r;
  logic signed [COEF_BITS-1:0] hp_pole_r, hp_pair_r, hp_gain_r;

  // filter state
  logic signed [S-1:0] lp_a_r, lp_b_r, lp_c_r, hp_a_r, hp_b_r, hp_c_r;

  // scratch
  logic signed [S-1:0]       acc_r, n_r, y_r, prod_r, prod_nxt;
  logic signed [MP_BITS-1:0] pp_r;
  logic signed [PW-1:0]      full_r, full_nxt;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sat;

  logic                  in_xfer, out_xfer, cfg_wr;
  reg_idx_t              reg_idx;
  logic signed [S-1:0]   alu_a, alu_b, alu_res;
  logic signed [S:0]     alu_sum;
  logic signed [COEF_BITS-1:0] mul_coef;
  logic signed [MOP_BITS-1:0]  mul_op;
  logic signed [HI_BITS-1:0]   op_hi;
  logic signed [MP_BITS-1:0]   mul_res;
  logic signed [PW:0]          rnd, shr;
  logic                        step_done, load_out;
  state_t                      adv_state;
  logic [PC_BITS-1:0]          adv_pc;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_xfer             = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_xfer            = out_valid_r && out_chan.ready;

  // --------------------------------------------------------------------------
  // APB register file (writes are always zero wait state)
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = {{(PDATA_BITS-2){1'b0}}, mode_r};
      REG_LP_POLE: prdata = lp_pole_r;
      REG_LP_PAIR: prdata = lp_pair_r;
      REG_LP_GAIN: prdata = lp_gain_r;
      REG_HP_POLE: prdata = hp_pole_r;
      REG_HP_PAIR: prdata = hp_pair_r;
      REG_HP_GAIN: prdata = hp_gain_r;
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Operand selection from the current micro-op
  // --------------------------------------------------------------------------
  assign uop = prog_uop(pc_r);

  function automatic logic signed [S-1:0] pick(src_t sel,
      logic signed [S-1:0] prod, logic signed [S-1:0] acc,
      logic signed [S-1:0] n, logic signed [S-1:0] y,
      logic signed [S-1:0] la, logic signed [S-1:0] lb, logic signed [S-1:0] lc,
      logic signed [S-1:0] ha, logic signed [S-1:0] hb, logic signed [S-1:0] hc);
    logic signed [S-1:0] v;
    case (sel)
      SRC_PROD: v = prod;
      SRC_ACC:  v = acc;
      SRC_N:    v = n;
      SRC_Y:    v = y;
      SRC_LPA:  v = la;
      SRC_LPB:  v = lb;
      SRC_LPC:  v = lc;
      SRC_HPA:  v = ha;
      SRC_HPB:  v = hb;
      SRC_HPC:  v = hc;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign alu_a = pick(uop.src_a, prod_r, acc_r, n_r, y_r,
                      lp_a_r, lp_b_r, lp_c_r, hp_a_r, hp_b_r, hp_c_r);
  assign alu_b = pick(uop.src_b, prod_r, acc_r, n_r, y_r,
                      lp_a_r, lp_b_r, lp_c_r, hp_a_r, hp_b_r, hp_c_r);

  // saturating add / subtract
  assign alu_sum = uop.sub ? ((S+1)'(alu_a) - (S+1)'(alu_b))
                           : ((S+1)'(alu_a) + (S+1)'(alu_b));
  assign alu_res = (alu_sum[S] != alu_sum[S-1]) ? (alu_sum[S] ? ST_MIN : ST_MAX)
                                                : alu_sum[S-1:0];

  // --------------------------------------------------------------------------
  // Shared multiplier: coef * state word, two partial products
  // --------------------------------------------------------------------------
  always_comb begin
    case (uop.coef)
      C_LP_POLE: mul_coef = lp_pole_r;
      C_LP_PAIR: mul_coef = lp_pair_r;
      C_LP_GAIN: mul_coef = lp_gain_r;
      C_HP_POLE: mul_coef = hp_pole_r;
      C_HP_PAIR: mul_coef = hp_pair_r;
      C_HP_GAIN: mul_coef = hp_gain_r;
      default:   mul_coef = '0;
    endcase
  end

  assign op_hi   = alu_a[S-1:LO_BITS];
  assign mul_op  = (state_r == S_EXEC) ? $signed({1'b0, alu_a[LO_BITS-1:0]})
                                       : MOP_BITS'(op_hi);
  assign mul_res = mul_op * mul_coef;

  assign full_nxt = (PW'(mul_res) <<< LO_BITS) + PW'(pp_r);

  // round half away from zero, then saturate to the state width
  assign rnd = (PW+1)'(full_r) + RND_HALF - (PW+1)'(full_r[PW-1]);
  assign shr = rnd >>> COEF_FRAC_BITS;
  always_comb begin
    if (!((&shr[PW:S-1]) || !(|shr[PW:S-1]))) begin
      prod_nxt = shr[PW] ? ST_MIN : ST_MAX;
    end else begin
      prod_nxt = shr[S-1:0];
    end
  end

  // output saturation to the sample width
  always_comb begin
    if (!((&y_r[S-1:SAMPLE_BITS-1]) || !(|y_r[S-1:SAMPLE_BITS-1]))) begin
      out_sat = y_r[S-1] ? SMP_MIN : SMP_MAX;
    end else begin
      out_sat = y_r[SAMPLE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    // next step after the current op retires; at a section end, jump to HP or finish
    if (!uop.last) begin
      adv_pc    = PC_BITS'(pc_r + 1'b1);
      adv_state = S_EXEC;
    end else if ((pc_r < HP_START) && mode_r[1]) begin
      adv_pc    = HP_START;
      adv_state = S_EXEC;
    end else begin
      adv_pc    = pc_r;
      adv_state = S_DONE;
    end
  end

  assign step_done = ((state_r == S_EXEC) && !uop.is_mul) || (state_r == S_MUL_RND);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (mode_r[0]) begin
            pc_nxt    = LP_START;
            state_nxt = S_EXEC;
          end else if (mode_r[1]) begin
            pc_nxt    = HP_START;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EXEC: begin
        if (uop.is_mul) begin
          state_nxt = S_MUL_HI;
        end else begin
          state_nxt = adv_state;
          pc_nxt    = adv_pc;
        end
      end
      S_MUL_HI: begin
        state_nxt = S_MUL_RND;
      end
      S_MUL_RND: begin
        state_nxt = adv_state;
        pc_nxt    = adv_pc;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= '0;
      lp_pole_r   <= '0;
      lp_pair_r   <= '0;
      lp_gain_r   <= '0;
      hp_pole_r   <= '0;
      hp_pair_r   <= '0;
      hp_gain_r   <= '0;
      lp_a_r      <= '0;
      lp_b_r      <= '0;
      lp_c_r      <= '0;
      hp_a_r      <= '0;
      hp_b_r      <= '0;
      hp_c_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        case (reg_idx)
          REG_MODE:    mode_r    <= pwdata[1:0];
          REG_LP_POLE: lp_pole_r <= pwdata;
          REG_LP_PAIR: lp_pair_r <= pwdata;
          REG_LP_GAIN: lp_gain_r <= pwdata;
          REG_HP_POLE: hp_pole_r <= pwdata;
          REG_HP_PAIR: hp_pair_r <= pwdata;
          REG_HP_GAIN: hp_gain_r <= pwdata;
          default: ;
        endcase
      end

      if (in_xfer && in_chan.trace_start) begin
        lp_a_r <= '0;
        lp_b_r <= '0;
        lp_c_r <= '0;
        hp_a_r <= '0;
        hp_b_r <= '0;
        hp_c_r <= '0;
      end else if ((state_r == S_EXEC) && !uop.is_mul) begin
        if (uop.wr_hpb) begin
          hp_b_r <= alu_res;
        end else begin
          case (uop.dst)
            DST_LPA: lp_a_r <= alu_res;
            DST_LPB: lp_b_r <= alu_res;
            DST_LPC: lp_c_r <= alu_res;
            DST_HPA: hp_a_r <= alu_res;
            DST_HPC: hp_c_r <= alu_res;
            default: ;
          endcase
        end
      end
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      y_r <= S'(in_chan.sample_in);
    end else if ((state_r == S_EXEC) && !uop.is_mul && !uop.wr_hpb) begin
      case (uop.dst)
        DST_ACC: acc_r <= alu_res;
        DST_N:   n_r   <= alu_res;
        DST_Y:   y_r   <= alu_res;
        default: ;
      endcase
    end

    if ((state_r == S_EXEC) && uop.is_mul) begin
      pp_r <= mul_res;
    end
    if (state_r == S_MUL_HI) begin
      full_r <= full_nxt;
    end
    if (state_r == S_MUL_RND) begin
      prod_r <= prod_nxt;
    end
    if (load_out) begin
      out_sample_r <= out_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (pc_r < PC_BITS'(PROG_LEN)))
    else $error("sequencer pc outside program");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_RND) |-> ($past(state_r) == S_MUL_HI && $past(state_r, 2) == S_EXEC))
    else $error("multiply phases out of order");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result produced outside done state");

  a_lp_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && pc_r < HP_START) |-> mode_r[0])
    else $error("low-pass section run while disabled");

  a_step_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (step_done && !uop.last) |=> (state_r == S_EXEC && pc_r == $past(pc_r) + 1'b1))
    else $error("program step did not advance");

endmodule
